### sv/spanning_forest_edges_defines.svh
// ----------------------------------------------------------------------------
// spanning_forest_edges_defines
// Assertion macros for the spanning-forest block; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SPANNING_FOREST_EDGES_DEFINES_SVH
`define SPANNING_FOREST_EDGES_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define SFE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("spanning_forest_edges: assertion failed");
// Expression must never be true outside reset
`define SFE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("spanning_forest_edges: forbidden condition seen");
`else
`define SFE_ASSERT(lbl, clk, rst_n, prop)
`define SFE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### sv/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants of the spanning-forest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  localparam int unsigned VertW   = 4;
  localparam int unsigned CountW  = 4;
  localparam int unsigned RowW    = 16;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned RowLimit = 16;

  localparam logic [CfgW-1:0]   VCOUNT_RESET = 5'd16;
  localparam logic [CountW-1:0] RESULT_CAP   = 4'd15;

  // Item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [VertW-1:0] row_index;
    logic [RowW-1:0]  row_bits;
  } in_word_t;

  typedef struct packed {
    logic [VertW-1:0]  edge_from;
    logic [VertW-1:0]  edge_to;
    logic              edge_valid;
    logic [CountW-1:0] edge_count;
    logic              is_last;
  } out_word_t;

  localparam out_word_t EMPTY_RESULT = '{
    edge_from: '0, edge_to: '0, edge_valid: 1'b0, edge_count: '0, is_last: 1'b1
  };

  // Controller to datapath
  typedef struct packed {
    logic load_row;
    logic init;
    logic scan;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;
    logic scan_last;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } sfe_state_e;

endpackage

`default_nettype wire

### sv/sfe_ctrl.sv
// ----------------------------------------------------------------------------
// sfe_ctrl
// Sequencer: accepts words, steps the pair scan, closes the compute run.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  input  wire                   kind_i,
  input  sfe_pkg::status_t      status_i,
  output logic                  busy,
  output sfe_pkg::cmd_t         cmd_o
);

  sfe_pkg::sfe_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      sfe_pkg::ST_IDLE: begin
        if (start) begin
          if (kind_i == sfe_pkg::KIND_LOAD) begin
            cmd_o.load_row = 1'b1;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = status_i.n_zero ? sfe_pkg::ST_DONE : sfe_pkg::ST_SCAN;
          end
        end
      end
      sfe_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = sfe_pkg::ST_DONE;
        end
      end
      sfe_pkg::ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = sfe_pkg::ST_IDLE;
      end
      default: begin
        state_d = sfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != sfe_pkg::ST_IDLE);

endmodule

`default_nettype wire

### sv/sfe_datapath.sv
// ----------------------------------------------------------------------------
// sfe_datapath
// Adjacency rows, component labels, pair counters and result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_datapath #(
  parameter int unsigned NumRows = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [sfe_pkg::CfgW-1:0]     cfg_wdata_i,
  input  sfe_pkg::in_word_t            in_i,
  input  sfe_pkg::cmd_t                cmd_i,
  output sfe_pkg::status_t             status_o,
  output sfe_pkg::out_word_t           result_o,
  output logic                         result_valid_o
);

  localparam int unsigned IdxW = $clog2(NumRows);
  localparam int unsigned CntW = $clog2(NumRows + 1);

  logic [sfe_pkg::CfgW-1:0]   vcount_q;
  logic [NumRows-1:0]         rows_q [NumRows];
  logic [IdxW-1:0]            labels_q [NumRows];
  logic [IdxW-1:0]            i_q, j_q;
  logic [sfe_pkg::CountW-1:0] found_q;
  sfe_pkg::out_word_t         pend_q, res_q;
  logic                       pend_valid_q, res_valid_q;

  logic [CntW-1:0]    n_act, n_last;
  logic [NumRows-1:0] row_sel;
  logic [IdxW-1:0]    lab_i, lab_j;
  logic               i_last, j_last, hit, emit;
  sfe_pkg::out_word_t emit_word, new_word;

  // Vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= sfe_pkg::VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // Vertices in use, clamped to the row storage
  always_comb begin
    if (32'(vcount_q) > NumRows) begin
      n_act = CntW'(NumRows);
    end else begin
      n_act = CntW'(vcount_q);
    end
    n_last = n_act - CntW'(1);
  end

  // Adjacency rows; indexes beyond storage are dropped
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row && (32'(in_i.row_index) < NumRows)) begin
      rows_q[in_i.row_index[IdxW-1:0]] <= in_i.row_bits[NumRows-1:0];
    end
  end

  // Current pair test
  always_comb begin
    row_sel = rows_q[i_q];
    lab_i   = labels_q[i_q];
    lab_j   = labels_q[j_q];
    i_last  = (CntW'(i_q) == n_last);
    j_last  = (CntW'(j_q) == n_last);
    hit     = cmd_i.scan && row_sel[j_q] && (lab_i != lab_j)
              && (found_q < sfe_pkg::RESULT_CAP);
  end

  assign status_o.n_zero    = (n_act == '0);
  assign status_o.scan_last = i_last && j_last;

  // Pair counters, row-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.init) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.scan) begin
      if (j_last) begin
        j_q <= '0;
        i_q <= i_q + IdxW'(1);
      end else begin
        j_q <= j_q + IdxW'(1);
      end
    end
  end

  // Labels: own index at init, parallel merge on a hit
  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < NumRows; k++) begin
      if (cmd_i.init) begin
        labels_q[k] <= IdxW'(k);
      end else if (hit && (labels_q[k] == lab_i)) begin
        labels_q[k] <= lab_j;
      end
    end
  end

  // Newly found edge
  always_comb begin
    new_word.edge_from  = sfe_pkg::VertW'(i_q);
    new_word.edge_to    = sfe_pkg::VertW'(j_q);
    new_word.edge_valid = 1'b1;
    new_word.edge_count = found_q + sfe_pkg::CountW'(1);
    new_word.is_last    = 1'b0;
  end

  // Pending edge: held until the next one or the end of the run shows is_last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      found_q      <= '0;
    end else if (cmd_i.init) begin
      pend_valid_q <= 1'b0;
      found_q      <= '0;
    end else if (hit) begin
      pend_valid_q <= 1'b1;
      found_q      <= found_q + sfe_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      pend_q <= new_word;
    end
  end

  // Word to emit this cycle
  always_comb begin
    emit      = 1'b0;
    emit_word = pend_q;
    if (cmd_i.finish) begin
      emit = 1'b1;
      if (pend_valid_q) begin
        emit_word.is_last = 1'b1;
      end else begin
        emit_word = sfe_pkg::EMPTY_RESULT;
      end
    end else if (hit && pend_valid_q) begin
      emit = 1'b1;
    end
  end

  // Output register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= emit_word;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

`default_nettype wire

### sv/spanning_forest_edges.sv
// ----------------------------------------------------------------------------
// spanning_forest_edges
// Spanning-forest search over a small undirected graph by component labeling.
// ----------------------------------------------------------------------------
// A load word (kind 0) writes one adjacency row; busy stays low. A compute
// word (kind 1) scans the n*n vertex pairs row-major at one pair per cycle,
// merging component labels in parallel on each forest edge, so busy is high
// through the scan state and the closing done state (only the done state for
// n = 0). Results come one per forest edge with result_valid_o high for a
// single cycle each; the receiver cannot stall them and must take each one.
// Every edge is held back one find so it can carry is_last; the final result
// shows as busy falls. A run with no edge gives one empty result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spanning_forest_edges_defines.svh"

module spanning_forest_edges #(
  parameter int unsigned MAX_VERTS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  sfe_pkg::in_word_t          in_i,
  input  wire                        cfg_we_i,
  input  wire  [sfe_pkg::CfgW-1:0]   cfg_wdata_i,
  output sfe_pkg::out_word_t         result_o,
  output logic                       result_valid_o
);

  localparam int unsigned NumRows =
    (MAX_VERTS < sfe_pkg::RowLimit) ? MAX_VERTS : sfe_pkg::RowLimit;

  sfe_pkg::cmd_t    cmd;
  sfe_pkg::status_t status;

  // Sequencer
  sfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (in_i.kind),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // Storage and scan datapath
  sfe_datapath #(
    .NumRows (NumRows)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // Results only come out of a compute run
  `SFE_ASSERT(a_result_from_run, clk_i, rst_ni, result_valid_o |-> $past(busy))
  // A compute start holds the block busy
  `SFE_ASSERT(a_compute_busy, clk_i, rst_ni,
    (start && !busy && (in_i.kind == sfe_pkg::KIND_COMPUTE)) |=> busy)
  // Closing a run always delivers the last word
  `SFE_ASSERT(a_finish_last, clk_i, rst_ni,
    cmd.finish |=> (result_valid_o && result_o.is_last))
  // An empty result only ever closes a run
  `SFE_ASSERT_NEVER(a_empty_last, clk_i, rst_ni,
    result_valid_o && !result_o.edge_valid && !result_o.is_last)

endmodule

`default_nettype wire
